// ----- rtl/core/rs_enc_pkg.sv -----
// ----------------------------------------------------------------------------
// rs_enc_pkg
// Shared widths, defaults and GF(256) arithmetic for the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rs_enc_pkg;

    localparam int DATA_W         = 8;
    localparam int CFG_W          = 5;
    localparam int MAX_PARITY_DEF = 30;
    localparam int RESET_PARITY   = 10;

    localparam logic [DATA_W-1:0] FIELD_LOW = 8'h1D;
    localparam logic [DATA_W-1:0] GF_ONE    = 8'h01;

    typedef logic [DATA_W-1:0] t_sym;

    function automatic t_sym gf_xtime(input t_sym a);
        gf_xtime = a[DATA_W-1] ? ({a[DATA_W-2:0], 1'b0} ^ FIELD_LOW)
                               : {a[DATA_W-2:0], 1'b0};
    endfunction

    function automatic t_sym gf_mul(input t_sym a, input t_sym b);
        t_sym acc;
        t_sym x;
        acc = '0;
        x   = a;
        for (int k = 0; k < DATA_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        gf_mul = acc;
    endfunction

endpackage

// ----- rtl/core/rs_enc_in_if.sv -----
// ----------------------------------------------------------------------------
// rs_enc_in_if
// Message byte channel into the encoder.
// ----------------------------------------------------------------------------
interface rs_enc_in_if;
    logic                         valid;
    logic                         ready;
    logic [rs_enc_pkg::DATA_W-1:0] data_byte;
    logic                         last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/rs_enc_out_if.sv -----
// ----------------------------------------------------------------------------
// rs_enc_out_if
// Data and parity byte channel out of the encoder.
// ----------------------------------------------------------------------------
interface rs_enc_out_if;
    logic                         valid;
    logic                         ready;
    logic [rs_enc_pkg::DATA_W-1:0] out_byte;
    logic                         is_parity;
    logic                         end_of_block;

    modport source (output valid, output out_byte, output is_parity, output end_of_block,
                    input ready);
    modport sink   (input valid, input out_byte, input is_parity, input end_of_block,
                    output ready);
endinterface

// ----- rtl/core/rs_enc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rs_enc_cfg_if
// Parity count register write channel.
// ----------------------------------------------------------------------------
interface rs_enc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rs_enc_pkg::CFG_W-1:0] parity_count;

    modport source (output valid, output parity_count, input ready);
    modport sink   (input valid, input parity_count, output ready);
endinterface

// ----- rtl/core/reed_solomon_parity_encoder.sv -----
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// Systematic RS encoder over GF(256), poly 0x11D, generator roots alpha^0..n-1.
//
//   channel  dir  beat payload
//   i_in     in   data_byte, last_byte
//   i_cfg    in   parity_count
//   o_out    out  out_byte, is_parity, end_of_block
//
// one message byte per cycle through a parallel lfsr into the output register
// a last byte adds n parity beats, emitted one per cycle from a shift register;
// i_in is held off until the last of them is loaded into the output register
// reset and each cfg beat rebuild the generator from its n roots, one at a time,
// with i_in and i_cfg held off; a pending cfg beat also holds off i_in
// o_out stalls back-pressure i_in and parity through the single output register
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder #(
    parameter int MAX_PARITY = rs_enc_pkg::MAX_PARITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rs_enc_in_if.sink          i_in,
    rs_enc_cfg_if.sink         i_cfg,
    rs_enc_out_if.source       o_out
);

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int VW = (CW > rs_enc_pkg::CFG_W) ? CW : rs_enc_pkg::CFG_W;
    localparam int RST_CNT = (rs_enc_pkg::RESET_PARITY > MAX_PARITY) ? MAX_PARITY
                                                                    : rs_enc_pkg::RESET_PARITY;

    rs_enc_pkg::t_sym r_rem [MAX_PARITY];
    rs_enc_pkg::t_sym n_rem [MAX_PARITY];
    rs_enc_pkg::t_sym r_gen [MAX_PARITY];
    rs_enc_pkg::t_sym n_gen [MAX_PARITY];
    rs_enc_pkg::t_sym r_par [MAX_PARITY];
    rs_enc_pkg::t_sym r_root;
    rs_enc_pkg::t_sym fb;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_build_left;
    logic [CW-1:0] r_par_left;
    logic [CW-1:0] cfg_count;
    logic [VW-1:0] cfg_ext;

    logic          r_out_valid;
    logic          r_out_par;
    logic          r_out_eob;
    rs_enc_pkg::t_sym r_out_byte;

    logic building;
    logic can_load;
    logic in_fire;
    logic cfg_fire;
    logic par_load;

    assign building = (r_build_left != '0);
    assign can_load = !r_out_valid || o_out.ready;
    assign i_in.ready = !building && !i_cfg.valid && can_load && (r_par_left == '0);
    assign i_cfg.ready = !building;
    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign par_load = can_load && (r_par_left != '0);

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.is_parity    = r_out_par;
    assign o_out.end_of_block = r_out_eob;

    // clamp the written count to 1..MAX_PARITY
    always_comb begin
        cfg_ext = VW'(i_cfg.parity_count);
        if (cfg_ext == '0) begin
            cfg_count = CW'(1);
        end else if (cfg_ext > VW'(MAX_PARITY)) begin
            cfg_count = CW'(MAX_PARITY);
        end else begin
            cfg_count = cfg_ext[CW-1:0];
        end
    end

    // lfsr step, entries above the count stay zero
    always_comb begin
        fb = i_in.data_byte ^ r_rem[0];
        for (int i = 0; i < MAX_PARITY; i++) begin
            n_rem[i] = rs_enc_pkg::gf_mul(fb, r_gen[i]);
            if (i < MAX_PARITY - 1) begin
                n_rem[i] = n_rem[i] ^ r_rem[i+1];
            end
        end
    end

    // multiply the generator by (x - root)
    always_comb begin
        n_gen[0] = r_gen[0] ^ r_root;
        for (int j = 1; j < MAX_PARITY; j++) begin
            n_gen[j] = r_gen[j] ^ rs_enc_pkg::gf_mul(r_root, r_gen[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= CW'(RST_CNT);
            r_build_left <= CW'(RST_CNT);
            r_root       <= rs_enc_pkg::GF_ONE;
            r_par_left   <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_PARITY; i++) begin
                r_rem[i] <= '0;
                r_gen[i] <= '0;
            end
        end else begin
            if (cfg_fire) begin
                r_count      <= cfg_count;
                r_build_left <= cfg_count;
                r_root       <= rs_enc_pkg::GF_ONE;
                for (int i = 0; i < MAX_PARITY; i++) begin
                    r_rem[i] <= '0;
                    r_gen[i] <= '0;
                end
            end else if (building) begin
                r_build_left <= r_build_left - CW'(1);
                r_root       <= rs_enc_pkg::gf_xtime(r_root);
                r_gen        <= n_gen;
            end

            if (in_fire) begin
                for (int i = 0; i < MAX_PARITY; i++) begin
                    r_rem[i] <= i_in.last_byte ? '0 : n_rem[i];
                end
                if (i_in.last_byte) begin
                    r_par_left <= r_count;
                end
            end else if (par_load) begin
                r_par_left <= r_par_left - CW'(1);
            end

            if (in_fire || par_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_byte <= i_in.data_byte;
            r_out_par  <= 1'b0;
            r_out_eob  <= 1'b0;
            r_par      <= n_rem;
        end else if (par_load) begin
            r_out_byte <= r_par[0];
            r_out_par  <= 1'b1;
            r_out_eob  <= (r_par_left == CW'(1));
            for (int i = 0; i < MAX_PARITY - 1; i++) begin
                r_par[i] <= r_par[i+1];
            end
            r_par[MAX_PARITY-1] <= '0;
        end
    end

`ifndef SYNTHESIS
    a_par_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.last_byte) |=> (r_par_left == $past(r_count)))
        else $error("parity countdown not loaded with count");

    a_eob_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.end_of_block) |-> o_out.is_parity)
        else $error("end of block on a data beat");

    a_eob_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.end_of_block) |-> (r_par_left == '0))
        else $error("parity beats left after end of block");

    a_cfg_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> (building && !i_in.ready))
        else $error("generator rebuild not started after cfg beat");
`endif

endmodule

// ----- bench/reed_solomon_parity_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder_tb
// Self-checking bench for the GF(256) Reed-Solomon parity encoder. Byte beats
// are fed through bursty traffic while the output side stalls in changing
// patterns. Every data and parity beat is predicted by a local LFSR encoder or
// the table, for parity counts 1 to 30, with blocks cut short by count writes.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_P      = rs_enc_pkg::MAX_PARITY_DEF;
    localparam int RAND_COUNT = -1;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 40;
    localparam int NROWS      = 23;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    typedef struct packed {
        t_row_kind        kind;
        logic [4:0]       cfg;
        rs_enc_pkg::t_sym data;
        logic             last;
        logic             known;
        rs_enc_pkg::t_sym par;
    } t_stim_row;

    typedef struct packed {
        rs_enc_pkg::t_sym out_byte;
        logic             is_parity;
        logic             end_of_block;
    } t_enc_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rs_enc_in_if  in_ch();
    rs_enc_cfg_if cfg_ch();
    rs_enc_out_if out_ch();

    reed_solomon_parity_encoder u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // typed parity for the beat on the wire, moves with the payload
    logic             typed_known;
    rs_enc_pkg::t_sym typed_par;

    int               errors = 0;
    int               burst_left = 0;
    t_enc_beat        beat_q[$];
    int unsigned      par_n;
    rs_enc_pkg::t_sym gen_coef [MAX_P];
    rs_enc_pkg::t_sym lfsr_rem [MAX_P];

    t_stim_row dir_rows [NROWS] = '{
        '{ROW_BYTE, 5'd0,  8'h00, 1'b1, 1'b1, 8'h00},
        '{ROW_BYTE, 5'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'hFF, 1'b1, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h00, 1'b1, 1'b1, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h33, 1'b0, 1'b0, 8'h00},
        // count of zero means one, and drops the open block
        '{ROW_CFG,  5'd0,  8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h5A, 1'b1, 1'b1, 8'h5A},
        '{ROW_BYTE, 5'd0,  8'hA5, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h0F, 1'b1, 1'b1, 8'hAA},
        '{ROW_BYTE, 5'd0,  8'hFF, 1'b1, 1'b1, 8'hFF},
        // above the maximum, clamps to 30
        '{ROW_CFG,  5'd31, 8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h00, 1'b1, 1'b1, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h80, 1'b1, 1'b0, 8'h00},
        '{ROW_CFG,  5'd30, 8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h55, 1'b1, 1'b0, 8'h00},
        '{ROW_CFG,  5'd1,  8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h00, 1'b1, 1'b1, 8'h00},
        '{ROW_CFG,  5'd2,  8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h80, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 5'd0,  8'h7F, 1'b1, 1'b0, 8'h00}
    };

    int cfg_plan [PHASES] = '{1, 30, 0, 31, RAND_COUNT, RAND_COUNT, 10,
                              RAND_COUNT, RAND_COUNT, 2};

    function automatic rs_enc_pkg::t_sym field_mult(rs_enc_pkg::t_sym a,
                                                    rs_enc_pkg::t_sym b);
        rs_enc_pkg::t_sym prod;
        rs_enc_pkg::t_sym sh;
        prod = '0;
        sh   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                prod = prod ^ sh;
            end
            sh = {sh[6:0], 1'b0} ^ (sh[7] ? rs_enc_pkg::FIELD_LOW : 8'h00);
        end
        return prod;
    endfunction

    function automatic void load_parity_count(logic [4:0] v);
        rs_enc_pkg::t_sym poly [MAX_P+1];
        rs_enc_pkg::t_sym root;
        int               n;
        n = v;
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_P) begin
            n = MAX_P;
        end
        par_n = n;
        foreach (poly[k]) poly[k] = '0;
        poly[0] = 8'h01;
        root    = 8'h01;
        for (int i = 0; i < n; i++) begin
            poly[i+1] = field_mult(root, poly[i]);
            for (int j = i; j >= 1; j--) begin
                poly[j] = poly[j] ^ field_mult(root, poly[j-1]);
            end
            root = field_mult(root, 8'h02);
        end
        for (int k = 0; k < MAX_P; k++) begin
            gen_coef[k] = (k < n) ? poly[k+1] : 8'h00;
            lfsr_rem[k] = '0;
        end
    endfunction

    function automatic void encode_beat(rs_enc_pkg::t_sym d, logic last, logic known,
                                        rs_enc_pkg::t_sym par);
        rs_enc_pkg::t_sym fb;
        fb = d ^ lfsr_rem[0];
        for (int i = 0; i + 1 < par_n; i++) begin
            lfsr_rem[i] = lfsr_rem[i+1] ^ field_mult(fb, gen_coef[i]);
        end
        lfsr_rem[par_n-1] = field_mult(fb, gen_coef[par_n-1]);
        beat_q.push_back('{d, 1'b0, 1'b0});
        if (last) begin
            for (int i = 0; i < par_n; i++) begin
                beat_q.push_back('{known ? par : lfsr_rem[i], 1'b1, i + 1 == par_n});
            end
            foreach (lfsr_rem[k]) lfsr_rem[k] = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_enc_beat want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                load_parity_count(cfg_ch.parity_count);
            end
            if (in_ch.valid && in_ch.ready) begin
                encode_beat(in_ch.data_byte, in_ch.last_byte, typed_known, typed_par);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (beat_q.size() == 0) begin
                    errors++;
                    $display("%0t: beat with none expected, actual out_byte=%h is_parity=%b eob=%b",
                             $time, out_ch.out_byte, out_ch.is_parity, out_ch.end_of_block);
                end else begin
                    want = beat_q.pop_front();
                    if (out_ch.out_byte !== want.out_byte) begin
                        errors++;
                        $display("%0t: out_byte mismatch, expected %h actual %h",
                                 $time, want.out_byte, out_ch.out_byte);
                    end
                    if (out_ch.is_parity !== want.is_parity) begin
                        errors++;
                        $display("%0t: is_parity mismatch, expected %b actual %b",
                                 $time, want.is_parity, out_ch.is_parity);
                    end
                    if (out_ch.end_of_block !== want.end_of_block) begin
                        errors++;
                        $display("%0t: end_of_block mismatch, expected %b actual %b",
                                 $time, want.end_of_block, out_ch.end_of_block);
                    end
                end
            end
        end
    end

    // output stalls
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   out_ch.ready <= 1'b1;
            RX_COIN:   out_ch.ready <= $urandom_range(0, 1);
            RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   out_ch.ready <= rx_left[2];
        endcase
    end

    // step past the current edge first so the beat accepted at that edge is already queued
    task automatic wait_drain();
        @(posedge i_clk);
        while (beat_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_beat(rs_enc_pkg::t_sym d, logic last, logic known,
                             rs_enc_pkg::t_sym par);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 40);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.last_byte <= last;
        typed_known     <= known;
        typed_par       <= par;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic write_parity_count(logic [4:0] v);
        in_ch.valid <= 1'b0;
        wait_drain();
        repeat (4) @(posedge i_clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.parity_count <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int               len;
        int               left;
        int               style;
        rs_enc_pkg::t_sym d;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.last_byte     <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.parity_count <= 5'(rs_enc_pkg::RESET_PARITY);
        typed_known         <= 1'b0;
        typed_par           <= '0;
        load_parity_count(5'(rs_enc_pkg::RESET_PARITY));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_parity_count(dir_rows[r].cfg);
            end else begin
                send_beat(dir_rows[r].data, dir_rows[r].last, dir_rows[r].known,
                          dir_rows[r].par);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_parity_count((cfg_plan[p] == RAND_COUNT) ? 5'($urandom_range(0, 31))
                                                            : 5'(cfg_plan[p]));
            left = PHASE_LEN;
            while (left > 0) begin
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48)
                                                    : $urandom_range(1, 6);
                style = $urandom_range(0, 9);
                for (int b = 0; b < len; b++) begin
                    d = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF
                                             : 8'($urandom_range(0, 255));
                    send_beat(d, b == len - 1, 1'b0, 8'h00);
                end
                left = left - len;
                if ($urandom_range(0, 15) == 0) begin
                    in_ch.valid <= 1'b0;
                    wait_drain();
                end
            end
            // open block left behind for the next count write
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0,
                                                        1'b0, 8'h00);
            end
        end

        in_ch.valid <= 1'b0;
        wait_drain();
        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS reed_solomon_parity_encoder");
        end else begin
            $display("FAIL reed_solomon_parity_encoder");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL reed_solomon_parity_encoder");
        $finish;
    end

endmodule
